// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_dpath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 4;
    localparam int STATUS_W = 2;

    // item opcodes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming item
        logic execute;  // update the store and load the result register
    } spq_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
// Controller for the sorted priority queue: item sequencing and output valid.
// Depends on spq_pkg; drives spq_dpath through spq_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output spq_pkg::spq_cmd_t    cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // a held result blocks intake until it is taken
    assign in_stall  = (state_reg != S_IDLE) | (out_valid_reg & out_stall);
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    assign cmd.capture = accept;
    assign cmd.execute = (state_reg == S_EXEC);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // output register is free here: intake required it drained
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/spq_dpath.sv =====
// Datapath for the sorted priority queue: row of sorted entry cells,
// fill count and result register. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_dpath #(
    parameter int DEPTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire spq_pkg::spq_cmd_t                    cmd,
    input  wire logic                                 mode,
    input  wire logic signed [spq_pkg::DATA_W-1:0]    value,
    output logic signed [spq_pkg::DATA_W-1:0]         removed_value,
    output logic [spq_pkg::STATUS_W-1:0]              status,
    output logic [spq_pkg::COUNT_W-1:0]               count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                     mode_reg;
    logic signed [DATA_W-1:0] value_reg;

    logic signed [DATA_W-1:0] entry_reg  [DEPTH];
    logic signed [DATA_W-1:0] entry_next [DEPTH];
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;

    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] removed_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [CW+COUNT_W-1:0]    fill_wide;

    logic [DEPTH-1:0]         keep;      // occupied and >= new value
    logic signed [DATA_W-1:0] ins_val [DEPTH];
    logic signed [DATA_W-1:0] rem_val [DEPTH];
    logic                     full;
    logic                     empty;

    assign full  = (fill_reg == CW'(DEPTH));
    assign empty = (fill_reg == '0);

    // each cell compares its own entry; keep[] is a prefix of the sorted row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign keep[i] = (CW'(i) < fill_reg) && (entry_reg[i] >= value_reg);
        if (i == 0)
        begin : g_head
            assign ins_val[i] = keep[i] ? entry_reg[i] : value_reg;
        end
        else
        begin : g_body
            assign ins_val[i] = keep[i]     ? entry_reg[i] :
                                keep[i-1]   ? value_reg    : entry_reg[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign rem_val[i] = entry_reg[i];
        end
        else
        begin : g_shift
            assign rem_val[i] = entry_reg[i+1];
        end
    end

    always_comb
    begin
        entry_next   = entry_reg;
        fill_next    = fill_reg;
        removed_next = '0;
        status_next  = ST_DONE;
        if (mode_reg == MODE_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                entry_next = ins_val;
                fill_next  = fill_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                removed_next = entry_reg[0];
                entry_next   = rem_val;
                fill_next    = fill_reg - CW'(1);
            end
        end
    end

    assign fill_wide = {{COUNT_W{1'b0}}, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.execute)
        begin
            fill_reg <= fill_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        if (cmd.execute)
        begin
            entry_reg   <= entry_next;
            removed_reg <= removed_next;
            status_reg  <= status_next;
            count_reg   <= fill_wide[COUNT_W-1:0];
        end
    end

    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign count         = count_reg;

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue (largest first).
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall, fields mode, value): mode 0 inserts
//   value behind every stored entry >= value; mode 1 removes the largest
//   (oldest of equal largest) entry. One transfer per edge with valid high
//   and stall low.
//   Output channel (out_valid / out_stall, fields removed_value, status,
//   count): exactly one result per item, in item order. status is done,
//   full (insert refused) or empty (remove refused); count is the number
//   of stored entries after the item, low 4 bits.
//   An item taken in the idle state moves to the controller's execute step,
//   where every cell of the entry row compares against the new value and
//   shifts in parallel, and its result is loaded into the output register.
//   Intake stays closed during the execute step, so a new item is not taken
//   before the last one is through; intake reopens once the result register is free.
//   Receiver stall: the result holds in the output register; in_stall stays
//   high while it waits, so nothing is lost.
//   Reset (rst_n low, asynchronous): queue empty, no result pending.
//   Stored entries are not cleared; only occupied cells affect any result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic signed [spq_pkg::DATA_W-1:0]    value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]         removed_value,
    output logic [spq_pkg::STATUS_W-1:0]              status,
    output logic [spq_pkg::COUNT_W-1:0]               count
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .value         (value),
        .removed_value (removed_value),
        .status        (status),
        .count         (count)
    );

endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker #(
    parameter int DEPTH = 8
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic signed [spq_pkg::DATA_W-1:0]    removed_value,
    input wire logic [spq_pkg::STATUS_W-1:0]         status,
    input wire logic [spq_pkg::COUNT_W-1:0]          count
);
    import spq_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(removed_value) && $stable(status)
                                   && $stable(count))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH)
                                           && removed_value == '0)
        else $error("full refusal with wrong count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0 && removed_value == '0)
        else $error("empty refusal with wrong count or value");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for sorted_priority_queue: directed corner items, then random
// insert/remove traffic with random idling on both channels and one long output hold.
// Depends on spq_pkg and the RTL under rtl/.
`timescale 1ns / 1ps
module tb;
    import spq_pkg::*;

    localparam int QDEPTH       = 8;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_AFTER   = 300;     // results seen before the long output hold
    localparam int HOLD_CYCLES  = 96;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } spq_result_t;

    // Shadow copy of the sorted store plus the results it still owes.
    class queue_shadow;
        logic signed [DATA_W-1:0] entries[$];   // index 0 holds the largest
        spq_result_t              owed[$];
        int                       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int fill();
            return entries.size();
        endfunction

        function void apply_item(logic m, logic signed [DATA_W-1:0] v);
            spq_result_t r;
            int          pos;
            r.removed = '0;
            r.status  = ST_DONE;
            if (m == MODE_INSERT) begin
                if (entries.size() >= QDEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // new value goes behind every entry >= it
                    pos = entries.size();
                    while (pos > 0 && entries[pos-1] < v)
                        pos--;
                    entries.insert(pos, v);
                end
            end
            else
            begin
                if (entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed = entries.pop_front();
            end
            r.count = COUNT_W'(entries.size());
            owed.push_back(r);
        endfunction

        function void match_result(logic signed [DATA_W-1:0] got_removed,
                                   logic [STATUS_W-1:0] got_status,
                                   logic [COUNT_W-1:0] got_count);
            spq_result_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: removed=%0d status=%0d count=%0d",
                             got_removed, got_status, got_count);
                return;
            end
            e = owed.pop_front();
            if (got_removed !== e.removed || got_status !== e.status
                || got_count !== e.count) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: exp removed=%0d status=%0d count=%0d, got removed=%0d status=%0d count=%0d",
                             e.removed, e.status, e.count,
                             got_removed, got_status, got_count);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     mode;
    logic signed [DATA_W-1:0] value;
    logic                     out_stall;
    wire logic                in_stall;
    wire logic                out_valid;
    wire logic signed [DATA_W-1:0] removed_value;
    wire logic [STATUS_W-1:0] status;
    wire logic [COUNT_W-1:0]  count;

    queue_shadow shadow;
    bit          send_idle_on;
    int unsigned cycles = 0;

    sorted_priority_queue #(
        .DEPTH(QDEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .removed_value(removed_value),
        .status       (status),
        .count        (count)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item after a random gap; returns once it has transferred.
    task automatic offer_item(input logic m, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        shadow.apply_item(m, v);
    endtask

    // Mix of full-range values, a narrow band for duplicates, and the extremes.
    function automatic int pick_value();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
            return $urandom;
        else if (kind <= 7)
            return $urandom_range(0, 8) - 4;
        else if (kind == 8)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 0;
                default: return -1;
            endcase
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                return 32'h7FFF_FFFF - $urandom_range(0, 3);
            else
                return 32'h8000_0000 + $urandom_range(0, 3);
        end
    endfunction

    task automatic directed_items();
        int i;
        offer_item(MODE_REMOVE, $urandom);        // remove while empty
        offer_item(MODE_INSERT, 32'h7FFF_FFFF);
        offer_item(MODE_INSERT, 32'h8000_0000);
        offer_item(MODE_INSERT, 0);
        offer_item(MODE_INSERT, -1);
        offer_item(MODE_INSERT, 5);
        offer_item(MODE_INSERT, 5);               // equal values keep arrival order
        offer_item(MODE_INSERT, 5);
        offer_item(MODE_INSERT, 1);               // store now full
        offer_item(MODE_INSERT, 7);               // refused: full
        offer_item(MODE_INSERT, 32'h8000_0000);   // refused: full
        for (i = 0; i < QDEPTH; i++)
            offer_item(MODE_REMOVE, $urandom);
        offer_item(MODE_REMOVE, $urandom);        // empty again
    endtask

    // Drift between fill-heavy and drain-heavy stretches so the count
    // sweeps the whole range and both refusals show up.
    task automatic random_items();
        int   i;
        bit   filling;
        logic m;
        filling = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 80 == 0)
                send_idle_on = ($urandom_range(0, 3) != 0);
            if (shadow.fill() >= QDEPTH)
                filling = 1'b0;
            else if (shadow.fill() == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 31) == 0)
                filling = ~filling;
            if ($urandom_range(0, 99) < (filling ? 75 : 25))
                m = MODE_INSERT;
            else
                m = MODE_REMOVE;
            offer_item(m, pick_value());
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Output side: random stall before each result, one long hold
    // so the result register backs up into the input channel.
    task automatic collect_results();
        int seen;
        int k;
        bit held;
        bit idle_on;
        seen    = 0;
        held    = 1'b0;
        idle_on = 1'b1;
        forever begin
            if (seen % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (!held && seen == HOLD_AFTER) begin
                held = 1'b1;
                k    = HOLD_CYCLES;
            end
            else
                k = idle_on ? $urandom_range(0, 8) : 0;
            if (k > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (k) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            shadow.match_result(removed_value, status, count);
            seen++;
        end
    endtask

    initial
    begin
        shadow       = new();
        send_idle_on = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_INSERT;
        value        = '0;
        out_stall    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            collect_results();
        join_none
        directed_items();
        random_items();
        while (shadow.owed.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
